// File: sv/bpra_pkg.sv
`timescale 1ns / 1ps
// Package for the bitmap page-run allocator: status codes, request kinds,
// sequencer states and fixed constants. It depends on nothing else.
package bpra_pkg;

   // Width of one free-map memory row and of the scan chunk taken each cycle, save while a new row is read.
   localparam int WORD_BITS  = 64;
   localparam int CHUNK_BITS = 8;
   localparam int PAGE_BITS  = 52;
   localparam int COUNT_BITS = 7;
   localparam int INDEX_BITS = 12;

   // Value of the top page register after reset.
   localparam logic [PAGE_BITS-1:0] TOP_RESET = 52'd4503599626584063;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NO_SPACE     = 2'd1,
      ST_OUT_OF_RANGE = 2'd2
   } status_type;

   // Request kinds.
   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FCHK,
      S_RD,
      S_CHEW,
      S_ASTART,
      S_MRD,
      S_MWR
   } state_type;

endpackage

// File: sv/bitmap_page_run_allocator.sv
`timescale 1ns / 1ps
// Sequence: allocate reads each 64-slot map row scanned and walks it in up to eight
// 8-bit scan steps, places the run start, then reads and writes each row of
// the run to mark it and answers. Free checks the range, then marks likewise;
// a bad request answers with no scan or mark. One request at a time; busy is
// high meanwhile. After reset a clearing pass writes the free map, slot 0 in
// use. The result beat lasts one cycle on rsp_valid; no receiver stall.
// Top level: first-fit contiguous page-run allocator over a free bitmap.
// Depends on bpra_pkg. SLOTS is assumed to be a multiple of 64.
module bitmap_page_run_allocator
   import bpra_pkg::*;
#(
   parameter int SLOTS   = 4096,
   parameter int MAX_RUN = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_action,
   input  logic [COUNT_BITS-1:0] req_page_count,
   input  logic [PAGE_BITS-1:0]  req_virtual_page,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [INDEX_BITS-1:0] rsp_slot_index,
   output logic [PAGE_BITS-1:0]  rsp_page_out,
   input  logic                  csr_write_enable,
   input  logic [PAGE_BITS-1:0]  csr_write_data
);

   localparam int ROWS      = SLOTS / WORD_BITS;
   localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int BIT_BITS  = $clog2(WORD_BITS);
   localparam int NCHUNK    = WORD_BITS / CHUNK_BITS;
   localparam int CHK_BITS  = $clog2(NCHUNK);
   localparam int KB        = $clog2(CHUNK_BITS);

   // Free map memory: one bit per slot, 1 means free.
   logic [WORD_BITS-1:0] mem [ROWS];
   logic [WORD_BITS-1:0] mem_q_ff;
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wd;

   state_type               state_ff, state_in;
   logic                    act_ff, act_in;
   logic [COUNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [PAGE_BITS-1:0]    slot_ff, slot_in;
   logic [SLOT_BITS-1:0]    start_ff, start_in;
   logic [SLOT_BITS-1:0]    end_ff, end_in;
   logic [ROW_BITS-1:0]     row_ff, row_in;
   logic [CHK_BITS-1:0]     chunk_ff, chunk_in;
   logic [COUNT_BITS-1:0]   run_ff, run_in;
   logic [PAGE_BITS-1:0]    top_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [INDEX_BITS-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [PAGE_BITS-1:0]    rsp_page_ff, rsp_page_in;

   logic                    accept;
   logic [ROW_BITS-1:0]     start_row;
   logic [ROW_BITS-1:0]     end_row;
   logic [BIT_BITS-1:0]     lo_bit;
   logic [BIT_BITS-1:0]     hi_bit;
   logic [WORD_BITS-1:0]    mark_mask;
   logic [CHUNK_BITS-1:0]   chunk_bits;
   logic                    hit;
   logic [KB-1:0]           hit_k;
   logic [COUNT_BITS-1:0]   run_v;
   logic [SLOT_BITS-1:0]    astart;
   logic [PAGE_BITS:0]      free_end;
   logic                    req_bad_count;

   assign busy           = (state_ff != S_IDLE);
   assign accept         = start && !busy;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_page_out   = rsp_page_ff;

   // Range of bits touched in the current row while marking a run.
   assign start_row = ROW_BITS'(start_ff >> BIT_BITS);
   assign end_row   = ROW_BITS'(end_ff >> BIT_BITS);
   assign lo_bit    = (row_ff == start_row) ? start_ff[BIT_BITS-1:0] : '0;
   assign hi_bit    = (row_ff == end_row) ? end_ff[BIT_BITS-1:0] : '1;
   assign mark_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                      ({WORD_BITS{1'b1}} >> (BIT_BITS'(WORD_BITS - 1) - hi_bit));

   // Scan step: walk eight map bits of the current row, counting free slots.
   assign chunk_bits = mem_q_ff[chunk_ff * CHUNK_BITS +: CHUNK_BITS];
   always_comb begin
      run_v = run_ff;
      hit   = 1'b0;
      hit_k = '0;
      for (int k = 0; k < CHUNK_BITS; k++) begin
         if (!hit) begin
            if (chunk_bits[k]) begin
               run_v = run_v + 1'b1;
               if (run_v == cnt_ff) begin
                  hit   = 1'b1;
                  hit_k = KB'(k);
               end
            end else begin
               run_v = '0;
            end
         end
      end
   end

   assign astart        = end_ff + 1'b1 - SLOT_BITS'(cnt_ff);
   assign free_end      = {1'b0, slot_ff} + (PAGE_BITS + 1)'(cnt_ff);
   assign req_bad_count = (req_page_count == '0) ||
                          (int'(req_page_count) > MAX_RUN) ||
                          (int'(req_page_count) > SLOTS);

   // Sequencer: next state, datapath updates and memory write.
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      cnt_in        = cnt_ff;
      slot_in       = slot_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      row_in        = row_ff;
      chunk_in      = chunk_ff;
      run_in        = run_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_page_in   = rsp_page_ff;
      mem_we        = 1'b0;
      mem_wd        = '0;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = {WORD_BITS{1'b1}};
            if (row_ff == '0) begin
               mem_wd[0] = 1'b0;
            end
            row_in = row_ff + 1'b1;
            if (row_ff == ROW_BITS'(ROWS - 1)) begin
               row_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in  = req_action;
               cnt_in  = req_page_count;
               slot_in = top_ff - req_virtual_page;
               if (req_action == ACT_FREE) begin
                  state_in = S_FCHK;
               end else if (req_bad_count) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NO_SPACE;
                  rsp_slot_in   = '0;
                  rsp_page_in   = '0;
               end else begin
                  row_in   = '0;
                  chunk_in = '0;
                  run_in   = '0;
                  state_in = S_RD;
               end
            end
         end
         S_FCHK: begin
            if ((cnt_ff == '0) || (int'(cnt_ff) > MAX_RUN) ||
                (slot_ff >= PAGE_BITS'(SLOTS)) ||
                (free_end > (PAGE_BITS + 1)'(SLOTS))) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OUT_OF_RANGE;
               rsp_slot_in   = INDEX_BITS'(slot_ff);
               rsp_page_in   = '0;
               state_in      = S_IDLE;
            end else begin
               start_in = SLOT_BITS'(slot_ff);
               end_in   = SLOT_BITS'(free_end - 1'b1);
               row_in   = ROW_BITS'(slot_ff >> BIT_BITS);
               state_in = S_MRD;
            end
         end
         S_RD: begin
            state_in = S_CHEW;
         end
         S_CHEW: begin
            run_in = run_v;
            if (hit) begin
               end_in   = SLOT_BITS'({row_ff, chunk_ff, hit_k});
               state_in = S_ASTART;
            end else begin
               chunk_in = chunk_ff + 1'b1;
               if (chunk_ff == CHK_BITS'(NCHUNK - 1)) begin
                  if (row_ff == ROW_BITS'(ROWS - 1)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_NO_SPACE;
                     rsp_slot_in   = '0;
                     rsp_page_in   = '0;
                     state_in      = S_IDLE;
                  end else begin
                     row_in   = row_ff + 1'b1;
                     state_in = S_RD;
                  end
               end
            end
         end
         S_ASTART: begin
            start_in = astart;
            row_in   = ROW_BITS'(astart >> BIT_BITS);
            state_in = S_MRD;
         end
         S_MRD: begin
            if (act_ff == ACT_ALLOC) begin
               rsp_page_in = top_ff - PAGE_BITS'(start_ff);
            end else begin
               rsp_page_in = '0;
            end
            state_in = S_MWR;
         end
         S_MWR: begin
            mem_we = 1'b1;
            if (act_ff == ACT_ALLOC) begin
               mem_wd = mem_q_ff & ~mark_mask;
            end else begin
               mem_wd = mem_q_ff | mark_mask;
            end
            if (row_ff == end_row) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_slot_in   = INDEX_BITS'(start_ff);
               state_in      = S_IDLE;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = S_MRD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Free map memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[row_ff] <= mem_wd;
      end
      mem_q_ff <= mem[row_ff];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         top_ff       <= TOP_RESET;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            top_ff <= csr_write_data;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      cnt_ff        <= cnt_in;
      slot_ff       <= slot_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      chunk_ff      <= chunk_in;
      run_ff        <= run_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_page_ff   <= rsp_page_in;
   end

   // The memory is written only by the clearing pass or a mark step.
   a_mem_write_src: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_MWR))
      else $error("free map written outside clear or mark");

   // A result beat always lands with the sequencer back at idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result beat while sequencer busy");

   // An accepted request either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid_ff))
      else $error("accepted request lost");

   // Marking stays within the rows of the run.
   a_mark_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MWR) |-> (row_ff >= start_row && row_ff <= end_row))
      else $error("mark row outside run");

endmodule
